// File: hdl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// shared sizes, types and control structs of the order book matcher
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int ORDER_SLOTS  = 64;
  localparam int PRICE_LEVELS = 1024;
  localparam int MAX_RESULTS  = 64;

  localparam int ID_W    = 64;
  localparam int PRICE_W = 10;
  localparam int QTY_W   = 32;

  localparam int SLOT_W    = $clog2(ORDER_SLOTS);
  localparam int PTR_W     = $clog2(ORDER_SLOTS + 1);
  localparam int LEVEL_W   = $clog2(PRICE_LEVELS);
  localparam int HADDR_W   = LEVEL_W + 1;
  localparam int HEAD_DEPTH = 2 * PRICE_LEVELS;
  localparam int CLR_W     = HADDR_W + 1;
  localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(ORDER_SLOTS);

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [QTY_W-1:0]   qty_t;

  // commands from sequencer to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic head_rd;
    logic step_lv;
    logic slot_rd;
    logic fill;
    logic emit_last;
    logic rest_rd;
    logic rest_wr;
  } lobm_cmd_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic clr_done;
    logic in_qty_zero;
    logic qty_zero;
    logic n_max;
    logic hd_nil;
    logic lv_end;
    logic full_fill;
    logic pend_v;
    logic out_free;
    logic pool_full;
  } lobm_sts_t;

endpackage

// File: hdl/lobm_in_if.sv
// ----------------------------------------------------------------------------
// lobm_in_if
// order channel: valid/ready with one limit order per word
// ----------------------------------------------------------------------------
interface lobm_in_if import lobm_pkg::*;;
  logic   valid;
  logic   ready;
  id_t    order_id;
  logic   is_sell;
  price_t limit_price;
  qty_t   quantity;

  modport source (output valid, order_id, is_sell, limit_price, quantity, input ready);
  modport sink   (input valid, order_id, is_sell, limit_price, quantity, output ready);
endinterface

// File: hdl/lobm_out_if.sv
// ----------------------------------------------------------------------------
// lobm_out_if
// trade channel: valid/ready with one fill per word
// ----------------------------------------------------------------------------
interface lobm_out_if import lobm_pkg::*;;
  logic   valid;
  logic   ready;
  price_t fill_price;
  qty_t   fill_qty;
  logic   last_trade;

  modport source (output valid, fill_price, fill_qty, last_trade, input ready);
  modport sink   (input valid, fill_price, fill_qty, last_trade, output ready);
endinterface

// File: hdl/lobm_datapath.sv
// ----------------------------------------------------------------------------
// lobm_datapath
// level head memory, order slot memories, free slot stack, trade registers
// ----------------------------------------------------------------------------
module lobm_datapath import lobm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lobm_cmd_t cmd,
  output lobm_sts_t sts,
  input  id_t       in_order_id,
  input  logic      in_is_sell,
  input  price_t    in_limit_price,
  input  qty_t      in_quantity,
  output logic      out_valid,
  input  logic      out_ready,
  output price_t    out_fill_price,
  output qty_t      out_fill_qty,
  output logic      out_last_trade
);

  // memories
  logic [PTR_W-1:0]  head_mem  [HEAD_DEPTH];
  price_t            slot_price [ORDER_SLOTS];
  qty_t              slot_qty   [ORDER_SLOTS];
  id_t               slot_id    [ORDER_SLOTS];
  logic [PTR_W-1:0]  slot_next  [ORDER_SLOTS];
  logic [SLOT_W-1:0] free_stack [ORDER_SLOTS];

  // order registers
  id_t                id_r;
  logic               sell_r;
  logic [LEVEL_W-1:0] price_r;
  qty_t               qty_r;
  logic [LEVEL_W-1:0] lv_r;
  logic [CNT_W-1:0]   n_r;

  // memory read data
  logic [PTR_W-1:0]  hd_rd_r;
  price_t            rd_price_r;
  qty_t              rd_qty_r;
  logic [PTR_W-1:0]  rd_next_r;
  logic [SLOT_W-1:0] stk_rd_r;

  // control registers
  logic              pend_v_r;
  price_t            pend_price_r;
  qty_t              pend_qty_r;
  logic              out_valid_r;
  price_t            out_price_r;
  qty_t              out_qty_r;
  logic              out_last_r;
  logic [PTR_W-1:0]  fresh_r;
  logic [PTR_W-1:0]  sp_r;
  logic [CLR_W-1:0]  clr_r;

  logic [LEVEL_W-1:0] in_lim;
  qty_t               take;
  logic [SLOT_W-1:0]  hd_slot;
  logic [SLOT_W-1:0]  alloc;
  logic [SLOT_W-1:0]  pop_idx;
  logic               fresh_avail;
  logic               out_free;

  // saturate the limit to the last level
  assign in_lim = (32'(in_limit_price) >= PRICE_LEVELS) ? LEVEL_W'(PRICE_LEVELS - 1)
                                                        : LEVEL_W'(in_limit_price);
  assign take        = (qty_r < rd_qty_r) ? qty_r : rd_qty_r;
  assign hd_slot     = hd_rd_r[SLOT_W-1:0];
  assign fresh_avail = (fresh_r < NIL_PTR);
  assign alloc       = fresh_avail ? fresh_r[SLOT_W-1:0] : stk_rd_r;
  assign pop_idx     = SLOT_W'(sp_r - PTR_W'(1));
  assign out_free    = !out_valid_r || out_ready;

  // status
  always_comb begin
    sts.clr_done    = (clr_r == CLR_W'(HEAD_DEPTH));
    sts.in_qty_zero = (in_quantity == '0);
    sts.qty_zero    = (qty_r == '0);
    sts.n_max       = (n_r == CNT_W'(MAX_RESULTS));
    sts.hd_nil      = (hd_rd_r == NIL_PTR);
    sts.lv_end      = (lv_r == price_r);
    sts.full_fill   = (rd_qty_r <= qty_r);
    sts.pend_v      = pend_v_r;
    sts.out_free    = out_free;
    sts.pool_full   = !fresh_avail && (sp_r == '0);
  end

  // level head memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      head_mem[clr_r[HADDR_W-1:0]] <= NIL_PTR;
    end else if (cmd.fill && sts.full_fill) begin
      head_mem[{~sell_r, lv_r}] <= rd_next_r;
    end else if (cmd.rest_wr) begin
      head_mem[{sell_r, price_r}] <= PTR_W'(alloc);
    end
    if (cmd.head_rd) begin
      hd_rd_r <= head_mem[{~sell_r, lv_r}];
    end else if (cmd.rest_rd) begin
      hd_rd_r <= head_mem[{sell_r, price_r}];
    end
  end

  // order slot memories
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      slot_qty[hd_slot] <= rd_qty_r - take;
    end else if (cmd.rest_wr) begin
      slot_qty[alloc]   <= qty_r;
      slot_price[alloc] <= PRICE_W'(price_r);
      slot_id[alloc]    <= id_r;
      slot_next[alloc]  <= hd_rd_r;
    end
    if (cmd.slot_rd) begin
      rd_price_r <= slot_price[hd_slot];
      rd_qty_r   <= slot_qty[hd_slot];
      rd_next_r  <= slot_next[hd_slot];
    end
  end

  // free slot stack of recycled slots
  always_ff @(posedge clk) begin
    if (cmd.fill && sts.full_fill) begin
      free_stack[sp_r[SLOT_W-1:0]] <= hd_slot;
    end
    if (cmd.rest_rd) begin
      stk_rd_r <= free_stack[pop_idx];
    end
  end

  // order payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_r    <= in_order_id;
      sell_r  <= in_is_sell;
      price_r <= in_lim;
      qty_r   <= in_quantity;
      n_r     <= '0;
      lv_r    <= in_is_sell ? LEVEL_W'(PRICE_LEVELS - 1) : '0;
    end else begin
      if (cmd.step_lv) begin
        lv_r <= sell_r ? lv_r - LEVEL_W'(1) : lv_r + LEVEL_W'(1);
      end
      if (cmd.fill) begin
        qty_r <= qty_r - take;
        n_r   <= n_r + CNT_W'(1);
      end
    end
    if (cmd.fill) begin
      pend_price_r <= rd_price_r;
      pend_qty_r   <= take;
    end
    if ((cmd.fill && pend_v_r) || cmd.emit_last) begin
      out_price_r <= pend_price_r;
      out_qty_r   <= pend_qty_r;
      out_last_r  <= cmd.emit_last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fresh_r     <= '0;
      sp_r        <= '0;
      clr_r       <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      // trade hand-off
      if (cmd.fill) begin
        pend_v_r <= 1'b1;
      end else if (cmd.emit_last) begin
        pend_v_r <= 1'b0;
      end
      if ((cmd.fill && pend_v_r) || cmd.emit_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // slot allocation
      if (cmd.fill && sts.full_fill) begin
        sp_r <= sp_r + PTR_W'(1);
      end else if (cmd.rest_wr) begin
        if (fresh_avail) begin
          fresh_r <= fresh_r + PTR_W'(1);
        end else begin
          sp_r <= sp_r - PTR_W'(1);
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fill_price = out_price_r;
  assign out_fill_qty   = out_qty_r;
  assign out_last_trade = out_last_r;

endmodule

// File: hdl/lobm_ctrl.sv
// ----------------------------------------------------------------------------
// lobm_ctrl
// sequencer: clearing pass, level scan, fills and resting of the remainder
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lobm_sts_t sts,
  output lobm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_HEAD, S_SLOT, S_FINISH, S_REST_RD, S_REST_WR
  } state_t;

  state_t state_r, state_nxt;

  // commands and next state
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_wr = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_qty_zero ? S_IDLE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.qty_zero || sts.n_max) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.head_rd = 1'b1;
          state_nxt   = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!sts.hd_nil) begin
          cmd.slot_rd = 1'b1;
          state_nxt   = S_SLOT;
        end else if (sts.lv_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step_lv = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SLOT: begin
        if (!sts.pend_v || sts.out_free) begin
          cmd.fill  = 1'b1;
          state_nxt = sts.full_fill ? S_SCAN : S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.pend_v || sts.out_free) begin
          cmd.emit_last = sts.pend_v;
          state_nxt = (sts.qty_zero || sts.pool_full) ? S_IDLE : S_REST_RD;
        end
      end
      S_REST_RD: begin
        cmd.rest_rd = 1'b1;
        state_nxt   = S_REST_WR;
      end
      S_REST_WR: begin
        cmd.rest_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/limit_order_book_matcher.sv
// steps: an order is accepted, each price level scanned takes a head read, each fill reads the
//   head and then the slot, the match is closed, and a remainder rests by a read and a write
// orders: one at a time, each as long as its level scan (up to all 1024 levels) and its fills,
//   plus any stall while the output register waits for the sink
// reset: synchronous, active low; a clearing pass empties every level head before the first
//   order is taken
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// matches one limit order against a two-sided book and emits one word per fill
// ----------------------------------------------------------------------------
module limit_order_book_matcher import lobm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  lobm_in_if.sink   in_ch,
  lobm_out_if.source out_ch
);

  lobm_cmd_t cmd;
  lobm_sts_t sts;

  // sequencer
  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // book storage and trade registers
  lobm_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_order_id     (in_ch.order_id),
    .in_is_sell      (in_ch.is_sell),
    .in_limit_price  (in_ch.limit_price),
    .in_quantity     (in_ch.quantity),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_fill_price  (out_ch.fill_price),
    .out_fill_qty    (out_ch.fill_qty),
    .out_last_trade  (out_ch.last_trade)
  );

  // a fill never overwrites a trade still waiting for the output register
  a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> (!sts.pend_v || sts.out_free))
    else $error("fill with pending trade blocked");

  // no order is taken before the clearing pass ends
  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    !sts.clr_done |-> !in_ch.ready)
    else $error("order accepted during clearing pass");

  // a remainder is only written when a slot is available
  a_rest_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rest_rd |=> (cmd.rest_wr && !sts.pool_full))
    else $error("rest without free slot");

endmodule

// File: bench/limit_order_book_matcher_test.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_test
// drives limit orders into the matcher, predicts every fill from a local copy
// of the book and compares each trade word against the oldest prediction
// ----------------------------------------------------------------------------
module limit_order_book_matcher_test;
  import lobm_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 4500;

  typedef struct {
    price_t price;
    qty_t   qty;
    logic   last;
  } trade_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   idle_cycles;
  bit   idling_on;

  lobm_in_if  in_ch ();
  lobm_out_if out_ch ();

  limit_order_book_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // local copy of the book
  int     bid_head [PRICE_LEVELS];
  int     ask_head [PRICE_LEVELS];
  price_t book_price [ORDER_SLOTS];
  qty_t   book_qty [ORDER_SLOTS];
  id_t    book_id [ORDER_SLOTS];
  int     book_next [ORDER_SLOTS];
  bit     book_free [ORDER_SLOTS];
  trade_t pending_trades[$];

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // count of free slots in the local book
  function automatic int free_slots();
    int cnt;
    cnt = 0;
    for (int s = 0; s < ORDER_SLOTS; s++) if (book_free[s]) cnt++;
    return cnt;
  endfunction

  // fill against one level, returns 1 when a resting order is left partly filled
  function automatic bit take_level(bit from_bids, int lv, ref qty_t qty, ref int n);
    int   s;
    qty_t t;
    while (((from_bids ? bid_head[lv] : ask_head[lv]) != ORDER_SLOTS) &&
           qty != 0 && n < MAX_RESULTS) begin
      s = from_bids ? bid_head[lv] : ask_head[lv];
      t = (qty < book_qty[s]) ? qty : book_qty[s];
      pending_trades.push_back('{price: book_price[s], qty: t, last: 1'b0});
      n++;
      qty -= t;
      book_qty[s] -= t;
      if (book_qty[s] == 0) begin
        if (from_bids) bid_head[lv] = book_next[s];
        else ask_head[lv] = book_next[s];
        book_free[s] = 1'b1;
      end else begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // predict the fills of one accepted order and update the book
  function automatic void match_order(id_t id, logic sell, price_t price, qty_t qty_in);
    qty_t qty;
    int   n;
    qty = qty_in;
    n = 0;
    if (qty == 0) return;
    if (!sell) begin
      for (int lv = 0; lv <= int'(price); lv++) begin
        if (qty == 0 || n >= MAX_RESULTS) break;
        if (take_level(1'b0, lv, qty, n)) break;
      end
    end else begin
      for (int lv = PRICE_LEVELS - 1; lv >= int'(price); lv--) begin
        if (qty == 0 || n >= MAX_RESULTS) break;
        if (take_level(1'b1, lv, qty, n)) break;
      end
    end
    if (n > 0) pending_trades[pending_trades.size() - 1].last = 1'b1;
    // rest the remainder in the first free slot, head of its level
    if (qty != 0) begin
      for (int s = 0; s < ORDER_SLOTS; s++) begin
        if (book_free[s]) begin
          book_free[s] = 1'b0;
          book_id[s] = id;
          book_price[s] = price;
          book_qty[s] = qty;
          if (sell) begin
            book_next[s] = ask_head[price];
            ask_head[price] = s;
          end else begin
            book_next[s] = bid_head[price];
            bid_head[price] = s;
          end
          break;
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // send one order word, called at a rising edge; predicts at acceptance
  task automatic send_order(id_t id, logic sell, price_t price, qty_t qty);
    in_ch.valid <= 1'b1;
    in_ch.order_id <= id;
    in_ch.is_sell <= sell;
    in_ch.limit_price <= price;
    in_ch.quantity <= qty;
    do @(posedge clk); while (!in_ch.ready);
    match_order(id, sell, price, qty);
    if (idling_on && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // hold off until every expected trade has come and the block is quiet
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_trades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic id_t rand_id();
    return {$urandom, $urandom};
  endfunction

  // extremes of every field, zero quantity, partial fill, sweep, lifo
  task automatic test_directed();
    send_order('0, 1'b0, '0, 32'd5);
    send_order('1, 1'b1, 10'd1023, 32'd7);
    send_order(rand_id(), 1'b0, 10'd600, 32'd0);
    send_order(rand_id(), 1'b1, 10'd0, 32'd3);
    send_order(rand_id(), 1'b0, 10'd1023, 32'hFFFF_FFFF);
    send_order(rand_id(), 1'b1, 10'd0, 32'hFFFF_FFFF);
    // lifo on one level, then a sweep over two levels ending in a partial fill
    send_order(rand_id(), 1'b1, 10'd300, 32'd4);
    send_order(rand_id(), 1'b1, 10'd300, 32'd9);
    send_order(rand_id(), 1'b1, 10'd301, 32'd2);
    send_order(rand_id(), 1'b1, 10'd302, 32'd6);
    send_order(rand_id(), 1'b0, 10'd302, 32'd17);
    send_order(rand_id(), 1'b0, 10'd299, 32'd1);
    send_order(rand_id(), 1'b1, 10'd299, 32'd1);
    send_order(rand_id(), 1'b0, 10'd1023, 32'hFFFF_FFFF);
    send_order(rand_id(), 1'b1, 10'd0, 32'hFFFF_FFFF);
  endtask

  // two more buys at one level than there are free slots, then a sell and a buy across all levels
  task automatic test_pool_full();
    int need;
    need = free_slots() + 2;
    for (int i = 0; i < need; i++) send_order(rand_id(), 1'b0, 10'd1, 32'd1);
    send_order(rand_id(), 1'b1, 10'd0, 32'hFFFF_FFFF);
    send_order(rand_id(), 1'b0, 10'd1023, 32'hFFFF_FFFF);
  endtask

  // random orders mostly in a narrow band so they cross often
  task automatic test_random(int count);
    price_t p;
    qty_t   q;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: p = price_t'($urandom);
        1: p = $urandom_range(1) ? 10'd1023 : 10'd0;
        default: p = price_t'($urandom_range(500, 520));
      endcase
      case ($urandom_range(11))
        0: q = '0;
        1: q = $urandom;
        default: q = $urandom_range(1, 40);
      endcase
      send_order(rand_id(), 1'($urandom), p, q);
      if (i == count / 2) wait_drained();
      if (i == (count * 3) / 4) idling_on = 1'b0;
    end
  endtask

  // result ready with random stalls
  always @(posedge clk) begin
    if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ch.ready <= (idle_cycles == 1);
    end else if (idling_on && $urandom_range(4) == 0) begin
      idle_cycles <= $urandom_range(1, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each trade word with the oldest prediction
  always @(posedge clk) begin
    trade_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_trades.size() == 0) begin
        report_mismatch("unexpected word fill_price", out_ch.fill_price, '0);
      end else begin
        want = pending_trades.pop_front();
        if (out_ch.fill_price !== want.price)
          report_mismatch("fill_price", out_ch.fill_price, want.price);
        if (out_ch.fill_qty !== want.qty)
          report_mismatch("fill_qty", out_ch.fill_qty, want.qty);
        if (out_ch.last_trade !== want.last)
          report_mismatch("last_trade", out_ch.last_trade, want.last);
      end
    end
  end

  // watchdog on cycles with no word moved
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    quiet_cycles = 0;
    idling_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.order_id = '0;
    in_ch.is_sell = 1'b0;
    in_ch.limit_price = '0;
    in_ch.quantity = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < PRICE_LEVELS; i++) begin
      bid_head[i] = ORDER_SLOTS;
      ask_head[i] = ORDER_SLOTS;
    end
    for (int s = 0; s < ORDER_SLOTS; s++) begin
      book_free[s] = 1'b1;
      book_next[s] = ORDER_SLOTS;
      book_qty[s] = '0;
      book_price[s] = '0;
      book_id[s] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pool_full();
    test_random(120);

    in_ch.valid <= 1'b0;
    while (pending_trades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_trades.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
